// ----- rtl/cfrt_pkg.sv -----
// Shared constants, codes and types of the CAN frame receiver table unit.
`timescale 1ns / 1ps
package cfrt_pkg;

   localparam int FRAME_BYTES   = 32;
   localparam int TABLE_ENTRIES = 16;

   localparam int STORE_IDX_W = $clog2(FRAME_BYTES);
   localparam int COUNT_W     = $clog2(FRAME_BYTES + 1);
   localparam int ENTRY_IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int SEARCH_W    = ($clog2(TABLE_ENTRIES + 1) > 5) ?
                                $clog2(TABLE_ENTRIES + 1) : 5;

   typedef logic [1:0] kind_type;
   typedef logic [2:0] status_type;
   typedef logic [1:0] csr_index_type;

   localparam kind_type KIND_BYTE  = 2'd0;
   localparam kind_type KIND_QUERY = 2'd1;
   localparam kind_type KIND_LOAD  = 2'd2;

   localparam status_type STAT_IDLE       = 3'd0;
   localparam status_type STAT_UPDATED    = 3'd1;
   localparam status_type STAT_NO_MATCH   = 3'd2;
   localparam status_type STAT_OVERFLOW   = 3'd3;
   localparam status_type STAT_QUERY_HIT  = 3'd4;
   localparam status_type STAT_QUERY_MISS = 3'd5;
   localparam status_type STAT_LOADED     = 3'd6;

   localparam csr_index_type CSR_START_BYTE   = 2'd0;
   localparam csr_index_type CSR_HEADER_LEN   = 2'd1;
   localparam csr_index_type CSR_SEND_CODE    = 2'd2;
   localparam csr_index_type CSR_ENTRIES_USED = 2'd3;

   localparam logic [7:0] START_BYTE_RESET   = 8'd254;
   localparam logic [3:0] HEADER_LEN_RESET   = 4'd2;
   localparam logic [7:0] SEND_CODE_RESET    = 8'd0;
   localparam logic [4:0] ENTRIES_USED_RESET = 5'd0;

endpackage

// ----- rtl/cfrt_if.sv -----
// Handshake channel interfaces of the CAN frame receiver table unit.
`timescale 1ns / 1ps
interface cfrt_req_if import cfrt_pkg::*; ();
   logic        valid;
   logic        ready;
   kind_type    kind;
   logic [7:0]  byte_value;
   logic [31:0] can_id;
   logic [3:0]  entry_index;

   modport source (output valid, kind, byte_value, can_id, entry_index, input ready);
   modport sink (input valid, kind, byte_value, can_id, entry_index, output ready);
endinterface

interface cfrt_rsp_if import cfrt_pkg::*; ();
   logic        valid;
   logic        ready;
   status_type  status;
   logic [3:0]  hit_index;
   logic [31:0] frame_id;
   logic [7:0]  data_length;
   logic [63:0] data_bytes;

   modport source (output valid, status, hit_index, frame_id, data_length, data_bytes,
                   input ready);
   modport sink (input valid, status, hit_index, frame_id, data_length, data_bytes,
                 output ready);
endinterface

interface cfrt_csr_if import cfrt_pkg::*; ();
   logic          valid;
   logic          ready;
   csr_index_type index;
   logic [7:0]    data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/can_frame_receiver_table_unit.sv -----
// Top level: serial deframer with a sequentially searched CAN entry table.
//
// Channels: req_ch takes one item per beat (a serial byte, a query by id or an
// entry id load); rsp_ch returns exactly one result beat per request beat, in
// order. csr_ch writes the four configuration registers and is always ready.
// Steps: a byte or load goes straight to the final step that raises rsp valid;
// a query goes through the search, a completed send frame through the frame
// check and then the search (skipped when its command byte differs). The
// search stops at a hit, or on a miss at the searched count (at most 16).
// The search is one 32-bit id comparator stepped over the table once a cycle.
// req_ch.ready is high only while the sequencer is idle; it rises in the same
// cycle as rsp valid, so the next request can be accepted while the previous
// result is still offered.
// The result register decouples the sides: a new request may be accepted and
// processed while the previous result waits; a stalled rsp_ch holds the
// sequencer in its final step until the result register frees.
// Reset (synchronous) returns registers to their defaults, closes any open
// frame, clears the frame store and the entry lengths and data.
`timescale 1ns / 1ps
module can_frame_receiver_table_unit import cfrt_pkg::*; (
   input logic        clock,
   input logic        reset,
   cfrt_req_if.sink   req_ch,
   cfrt_rsp_if.source rsp_ch,
   cfrt_csr_if.sink   csr_ch
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_FRAME  = 2'd1;
   localparam logic [1:0] ST_SEARCH = 2'd2;
   localparam logic [1:0] ST_DONE   = 2'd3;

   logic [7:0] start_byte_ff;
   logic [3:0] header_len_ff;
   logic [7:0] send_code_ff;
   logic [4:0] entries_used_ff;

   logic [1:0]          state_ff, state_in;
   logic                in_frame_ff, in_frame_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic [7:0]          paylen_ff, paylen_in;
   logic [SEARCH_W-1:0] cnt_ff, cnt_in;
   logic [31:0]         target_ff, target_in;
   logic                mode_frame_ff, mode_frame_in;

   status_type  res_status_ff, res_status_in;
   logic [3:0]  res_hit_ff, res_hit_in;
   logic [31:0] res_fid_ff, res_fid_in;
   logic [7:0]  res_len_ff, res_len_in;
   logic [63:0] res_data_ff, res_data_in;

   logic        rsp_valid_ff, rsp_valid_in;
   status_type  rsp_status_ff, rsp_status_in;
   logic [3:0]  rsp_hit_ff, rsp_hit_in;
   logic [31:0] rsp_fid_ff, rsp_fid_in;
   logic [7:0]  rsp_len_ff, rsp_len_in;
   logic [63:0] rsp_data_ff, rsp_data_in;

   logic [7:0]  store_ff [FRAME_BYTES];
   logic [31:0] entry_id_ff [TABLE_ENTRIES];
   logic [7:0]  entry_len_ff [TABLE_ENTRIES];
   logic [63:0] entry_data_ff [TABLE_ENTRIES];

   logic                   store_we;
   logic [STORE_IDX_W-1:0] store_wa;
   logic                   id_we;
   logic                   ent_we;

   logic                         req_fire;
   logic [COUNT_W-1:0]           count_nxt;
   logic [8:0]                   frame_end;
   logic [SEARCH_W-1:0]          used_ext;
   logic [SEARCH_W-1:0]          search_lim;
   logic [ENTRY_IDX_W-1:0]       cnt_idx;
   logic [SEARCH_W+3:0]          cnt_pad;
   logic [ENTRY_IDX_W+3:0]       load_pad;
   logic                         load_ok;
   logic [31:0]                  store_id;
   logic [63:0]                  store_data;
   logic                         out_free;

   assign req_fire    = req_ch.valid && req_ch.ready;
   assign req_ch.ready = (state_ff == ST_IDLE);
   assign csr_ch.ready = 1'b1;

   assign count_nxt  = count_ff + COUNT_W'(1);
   assign frame_end  = 9'(paylen_ff) + 9'(header_len_ff) + 9'd1;
   assign used_ext   = SEARCH_W'(entries_used_ff);
   assign search_lim = (used_ext > SEARCH_W'(TABLE_ENTRIES)) ?
                       SEARCH_W'(TABLE_ENTRIES) : used_ext;
   assign cnt_idx    = cnt_ff[ENTRY_IDX_W-1:0];
   assign cnt_pad    = {4'd0, cnt_ff};
   assign load_pad   = {{ENTRY_IDX_W{1'b0}}, req_ch.entry_index};
   assign load_ok    = load_pad < (ENTRY_IDX_W + 4)'(TABLE_ENTRIES);
   assign store_id   = {store_ff[6], store_ff[5], store_ff[4], store_ff[3]};
   assign store_data = {store_ff[15], store_ff[14], store_ff[13], store_ff[12],
                        store_ff[11], store_ff[10], store_ff[9], store_ff[8]};
   assign out_free   = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      state_in      = state_ff;
      in_frame_in   = in_frame_ff;
      count_in      = count_ff;
      paylen_in     = paylen_ff;
      cnt_in        = cnt_ff;
      target_in     = target_ff;
      mode_frame_in = mode_frame_ff;
      res_status_in = res_status_ff;
      res_hit_in    = res_hit_ff;
      res_fid_in    = res_fid_ff;
      res_len_in    = res_len_ff;
      res_data_in   = res_data_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_hit_in    = rsp_hit_ff;
      rsp_fid_in    = rsp_fid_ff;
      rsp_len_in    = rsp_len_ff;
      rsp_data_in   = rsp_data_ff;
      store_we      = 1'b0;
      store_wa      = count_ff[STORE_IDX_W-1:0];
      id_we         = 1'b0;
      ent_we        = 1'b0;

      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               res_status_in = STAT_IDLE;
               res_hit_in    = 4'd0;
               res_fid_in    = 32'd0;
               res_len_in    = 8'd0;
               res_data_in   = 64'd0;
               state_in      = ST_DONE;
               unique case (req_ch.kind)
                  KIND_BYTE: begin
                     if (!in_frame_ff) begin
                        if (req_ch.byte_value == start_byte_ff) begin
                           in_frame_in = 1'b1;
                           store_we    = 1'b1;
                           store_wa    = '0;
                           count_in    = COUNT_W'(1);
                           paylen_in   = 8'd0;
                        end
                     end else begin
                        store_we = 1'b1;
                        count_in = count_nxt;
                        priority if (count_nxt == COUNT_W'(2)) begin
                           paylen_in = req_ch.byte_value;
                        end else if (9'(count_nxt) == frame_end) begin
                           in_frame_in = 1'b0;
                           state_in    = ST_FRAME;
                        end else if (count_nxt >= COUNT_W'(FRAME_BYTES)) begin
                           in_frame_in   = 1'b0;
                           res_status_in = STAT_OVERFLOW;
                        end else begin
                           count_in = count_nxt;
                        end
                     end
                  end
                  KIND_QUERY: begin
                     target_in     = req_ch.can_id;
                     cnt_in        = '0;
                     mode_frame_in = 1'b0;
                     state_in      = ST_SEARCH;
                  end
                  KIND_LOAD: begin
                     id_we         = load_ok;
                     res_status_in = STAT_LOADED;
                  end
                  default: begin
                     res_status_in = STAT_IDLE;
                  end
               endcase
            end
         end
         ST_FRAME: begin
            res_status_in = STAT_NO_MATCH;
            if (store_ff[2] != send_code_ff) begin
               state_in = ST_DONE;
            end else begin
               res_fid_in    = store_id;
               target_in     = store_id;
               cnt_in        = '0;
               mode_frame_in = 1'b1;
               state_in      = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            priority if (cnt_ff == search_lim) begin
               res_status_in = mode_frame_ff ? STAT_NO_MATCH : STAT_QUERY_MISS;
               state_in      = ST_DONE;
            end else if (entry_id_ff[cnt_idx] == target_ff) begin
               res_hit_in = cnt_pad[3:0];
               state_in   = ST_DONE;
               if (mode_frame_ff) begin
                  ent_we        = 1'b1;
                  res_status_in = STAT_UPDATED;
                  res_len_in    = store_ff[7];
                  res_data_in   = store_data;
               end else begin
                  res_status_in = STAT_QUERY_HIT;
                  res_len_in    = entry_len_ff[cnt_idx];
                  res_data_in   = entry_data_ff[cnt_idx];
               end
            end else begin
               cnt_in = cnt_ff + SEARCH_W'(1);
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_hit_in    = res_hit_ff;
               rsp_fid_in    = res_fid_ff;
               rsp_len_in    = res_len_ff;
               rsp_data_in   = res_data_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_byte_ff   <= START_BYTE_RESET;
         header_len_ff   <= HEADER_LEN_RESET;
         send_code_ff    <= SEND_CODE_RESET;
         entries_used_ff <= ENTRIES_USED_RESET;
      end else if (csr_ch.valid && csr_ch.ready) begin
         unique case (csr_ch.index)
            CSR_START_BYTE:   start_byte_ff   <= csr_ch.data;
            CSR_HEADER_LEN:   header_len_ff   <= csr_ch.data[3:0];
            CSR_SEND_CODE:    send_code_ff    <= csr_ch.data;
            CSR_ENTRIES_USED: entries_used_ff <= csr_ch.data[4:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         in_frame_ff  <= 1'b0;
         count_ff     <= '0;
         paylen_ff    <= 8'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         in_frame_ff  <= in_frame_in;
         count_ff     <= count_in;
         paylen_ff    <= paylen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff        <= cnt_in;
      target_ff     <= target_in;
      mode_frame_ff <= mode_frame_in;
      res_status_ff <= res_status_in;
      res_hit_ff    <= res_hit_in;
      res_fid_ff    <= res_fid_in;
      res_len_ff    <= res_len_in;
      res_data_ff   <= res_data_in;
      rsp_status_ff <= rsp_status_in;
      rsp_hit_ff    <= rsp_hit_in;
      rsp_fid_ff    <= rsp_fid_in;
      rsp_len_ff    <= rsp_len_in;
      rsp_data_ff   <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < FRAME_BYTES; i++) begin
            store_ff[i] <= 8'd0;
         end
      end else if (store_we) begin
         store_ff[store_wa] <= req_ch.byte_value;
      end
   end

   always_ff @(posedge clock) begin
      if (id_we) begin
         entry_id_ff[load_pad[ENTRY_IDX_W-1:0]] <= req_ch.can_id;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TABLE_ENTRIES; i++) begin
            entry_len_ff[i]  <= 8'd0;
            entry_data_ff[i] <= 64'd0;
         end
      end else if (ent_we) begin
         entry_len_ff[cnt_idx]  <= store_ff[7];
         entry_data_ff[cnt_idx] <= store_data;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.status      = rsp_status_ff;
   assign rsp_ch.hit_index   = rsp_hit_ff;
   assign rsp_ch.frame_id    = rsp_fid_ff;
   assign rsp_ch.data_length = rsp_len_ff;
   assign rsp_ch.data_bytes  = rsp_data_ff;

`ifndef SYNTHESIS
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result beat raised outside the final step");

   a_search_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEARCH) |-> (cnt_ff <= search_lim))
      else $error("entry search ran past the searched count");

   a_frame_count: assert property (@(posedge clock) disable iff (reset)
      in_frame_ff |-> (count_ff != '0 && count_ff < COUNT_W'(FRAME_BYTES)))
      else $error("open frame with byte count out of range");

   a_done_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && rsp_valid_ff && !rsp_ch.ready) |=> (state_ff == ST_DONE))
      else $error("result dropped while output stalled");
`endif

endmodule
